FILE: sv/cse_pkg.sv
// Shared types and constants for the cubic spline evaluator.
// Holds the request and result structs, command, status and register codes.
// No dependencies; every other file refers to it by scoped names.
package cse_pkg;

    // Sizing of the knot store and of the number formats
    localparam int unsigned KNOT_VECTOR_LIMIT = 64;
    localparam int unsigned COMPONENT_LIMIT   = 4;
    localparam int unsigned STORE_DEPTH = 256;
    localparam int unsigned STORE_AW    = 8;
    localparam int unsigned KNOT_W      = 32;
    localparam int unsigned COEF_W      = 16;
    localparam int unsigned COEF_FRAC   = 12;
    localparam int unsigned T_FRAC      = 16;
    localparam int unsigned ALPHA_W     = 17;
    localparam int unsigned COUNT_W     = 7;
    localparam int unsigned VPK_W       = 3;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned MIN_KNOTS   = 4;
    localparam int unsigned SPAN_TAIL   = 3;

    // Limits folded into the register widths
    localparam int unsigned KNOT_CAP =
        (KNOT_VECTOR_LIMIT < (2**COUNT_W - 1)) ? KNOT_VECTOR_LIMIT : (2**COUNT_W - 1);
    localparam int unsigned DEPTH_LIMIT = (COMPONENT_LIMIT < 4) ? COMPONENT_LIMIT : 4;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

    // Reset values of the configuration registers
    localparam logic [COUNT_W-1:0] KNOT_COUNT_RESET = COUNT_W'(4);
    localparam logic [VPK_W-1:0]   VPK_RESET        = VPK_W'(3);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KNOT_COUNT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VALUES_PER_KNOT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASIS_ROW_ZERO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASIS_ROW_ONE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASIS_ROW_TWO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASIS_ROW_THREE = 3'd5;

    // Result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_TOO_FEW = 1'b1;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_EVAL  = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                       command;
        logic [STORE_AW-1:0]        knot_index;
        logic signed [KNOT_W-1:0]   knot_value;
        logic [ALPHA_W-1:0]         alpha;
    } req_t;

    typedef struct packed {
        logic signed [KNOT_W-1:0]   value;
        logic [1:0]                 component;
        logic                       last;
        logic                       status;
    } rsp_t;

endpackage

FILE: sv/cubic_spline_evaluator.sv
// Cubic spline evaluator top level: knot store, sequencer and shared multiplier.
// Depends on cse_pkg for the request and result structs and all codes.
//
// A write request stores one Q16.16 knot component. An evaluate request passes
// through the scale and split setup states, then for each component fetches the
// four span knots through the registered read port of the store, runs the sixteen
// basis multiply-accumulates and the three Horner steps, and hands over the
// result. All of it runs through one registered 41 x 18 bit multiplier, and the
// block takes no new request until the last result of an evaluation has been
// taken. An evaluation with fewer than four knots loaded gives a single error
// result in the cycle after it is accepted. Knot store entries hold no defined
// value until written.
module cubic_spline_evaluator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  cse_pkg::req_t                       req_data,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output cse_pkg::rsp_t                       rsp_data,
    input  logic                                cfg_write,
    input  logic [cse_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cse_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int unsigned ACC_W      = 50;
    localparam int unsigned P_W        = 38;
    localparam int unsigned H_W        = 41;
    localparam int unsigned MUL_A_W    = H_W;
    localparam int unsigned MUL_B_W    = cse_pkg::ALPHA_W + 1;
    localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
    localparam int unsigned ADDR_SUM_W = 11;
    localparam int unsigned KW         = cse_pkg::KNOT_W;
    localparam int unsigned CW         = cse_pkg::COUNT_W;

    localparam logic signed [H_W-1:0] SAT_HI = H_W'(2147483647);
    localparam logic signed [H_W-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_SCALE = 8'b00000010,
        ST_SPLIT = 8'b00000100,
        ST_FETCH = 8'b00001000,
        ST_MAC   = 8'b00010000,
        ST_HMUL  = 8'b00100000,
        ST_HADD  = 8'b01000000,
        ST_OUT   = 8'b10000000
    } state_t;

    // Control state
    state_t      state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [1:0]  comp_reg, comp_next;
    logic        mac_vld_reg, mac_vld_next;

    // Configuration registers
    logic [CW-1:0]                                     knot_count_reg;
    logic [cse_pkg::VPK_W-1:0]                         vpk_reg;
    logic [3:0][3:0][cse_pkg::COEF_W-1:0]              basis_reg;

    // Datapath registers
    logic [CW-1:0]                   nspans_reg;
    logic [cse_pkg::VPK_W-1:0]       depth_reg;
    logic [cse_pkg::ALPHA_W-1:0]     alpha_reg;
    logic [CW-1:0]                   span_reg;
    logic [cse_pkg::ALPHA_W-1:0]     t_reg;
    logic signed [KW-1:0]            knot_reg [4];
    logic signed [P_W-1:0]           p_reg [4];
    logic signed [ACC_W-1:0]         acc_reg;
    logic signed [PROD_W-1:0]        prod_reg;
    logic [3:0]                      tag_reg;
    logic signed [H_W-1:0]           h_reg;
    logic [KW-1:0]                   rd_data_reg;
    cse_pkg::rsp_t                   rsp_reg;

    logic [KW-1:0] store [cse_pkg::STORE_DEPTH];

    // Combinational signals
    logic                            req_fire, eval_fire, write_fire, rsp_fire;
    logic [CW-1:0]                   n_eff;
    logic                            too_few;
    logic [cse_pkg::VPK_W-1:0]       depth_eff;
    logic [cse_pkg::ALPHA_W-1:0]     alpha_sat;
    logic signed [MUL_A_W-1:0]       mul_a;
    logic signed [MUL_B_W-1:0]       mul_b;
    logic signed [PROD_W-1:0]        mul_out;
    logic signed [cse_pkg::COEF_W-1:0] coef_sel;
    logic signed [KW-1:0]            knot_sel;
    logic [ADDR_SUM_W-1:0]           addr_sum;
    logic [cse_pkg::STORE_AW-1:0]    rd_addr;
    logic [1:0]                      fetch_slot;
    logic [CW-1:0]                   span_raw, span_clamp;
    logic [23:0]                     t_full;
    logic signed [ACC_W-1:0]         acc_sum, p_tmp, p_shift;
    logic signed [P_W-1:0]           p_new, p_sel;
    logic signed [PROD_W-1:0]        h_tmp, h_shift;
    logic signed [H_W-1:0]           h_sum;
    logic signed [KW-1:0]            sat_value;
    logic                            last_comp;
    logic                            mac_issue;

    // Handshakes
    assign req_ready  = (state_reg == ST_IDLE);
    assign req_fire   = req_valid && req_ready;
    assign eval_fire  = req_fire && (req_data.command == cse_pkg::CMD_EVAL);
    assign write_fire = req_fire && (req_data.command == cse_pkg::CMD_WRITE);
    assign rsp_valid  = (state_reg == ST_OUT);
    assign rsp_data   = rsp_reg;
    assign rsp_fire   = rsp_valid && rsp_ready;

    // Effective knot count, component count and evaluation point
    assign n_eff = (knot_count_reg > CW'(cse_pkg::KNOT_CAP)) ?
                   CW'(cse_pkg::KNOT_CAP) : knot_count_reg;
    assign too_few = (n_eff < CW'(cse_pkg::MIN_KNOTS));

    always_comb
    begin
        if (vpk_reg == '0)
            depth_eff = cse_pkg::VPK_W'(1);
        else if (vpk_reg > cse_pkg::VPK_W'(cse_pkg::DEPTH_LIMIT))
            depth_eff = cse_pkg::VPK_W'(cse_pkg::DEPTH_LIMIT);
        else
            depth_eff = vpk_reg;
    end

    assign alpha_sat = (req_data.alpha > cse_pkg::ALPHA_ONE) ?
                       cse_pkg::ALPHA_ONE : req_data.alpha;

    // Span and local fraction from the scaled evaluation point
    assign span_raw   = prod_reg[cse_pkg::T_FRAC +: CW];
    assign span_clamp = (span_raw >= nspans_reg) ? (nspans_reg - CW'(1)) : span_raw;
    assign t_full     = prod_reg[23:0] - {1'b0, span_clamp, 16'h0000};

    // Store address of knot slot k of the span for the current component
    assign fetch_slot = cnt_reg[1:0];
    assign addr_sum   = (ADDR_SUM_W'(span_reg) + ADDR_SUM_W'(fetch_slot))
                        * ADDR_SUM_W'(depth_reg) + ADDR_SUM_W'(comp_reg);
    assign rd_addr    = addr_sum[cse_pkg::STORE_AW-1:0];

    // Operand selection for the shared multiplier
    assign coef_sel  = $signed(basis_reg[cnt_reg[3:2]][cnt_reg[1:0]]);
    assign knot_sel  = knot_reg[cnt_reg[1:0]];
    assign mac_issue = !cnt_reg[4];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SCALE:
            begin
                mul_a = $signed({{(MUL_A_W-CW){1'b0}}, nspans_reg});
                mul_b = $signed({1'b0, alpha_reg});
            end
            ST_MAC:
            begin
                mul_a = {{(MUL_A_W-KW){knot_sel[KW-1]}}, knot_sel};
                mul_b = {{(MUL_B_W-cse_pkg::COEF_W){coef_sel[cse_pkg::COEF_W-1]}}, coef_sel};
            end
            ST_HMUL:
            begin
                mul_a = h_reg;
                mul_b = $signed({1'b0, t_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_out = mul_a * mul_b;

    // Accumulation of one basis row and rounding of Q.28 down to Q16.16
    assign acc_sum = acc_reg + $signed(prod_reg[ACC_W-1:0]);
    assign p_tmp   = acc_sum + ACC_W'(2**(cse_pkg::COEF_FRAC-1));
    assign p_shift = p_tmp >>> cse_pkg::COEF_FRAC;
    assign p_new   = $signed(p_shift[P_W-1:0]);

    // Horner step: p_r plus the rounded product of h and t
    assign p_sel   = p_reg[cnt_reg[1:0]];
    assign h_tmp   = prod_reg + PROD_W'(2**(cse_pkg::T_FRAC-1));
    assign h_shift = h_tmp >>> cse_pkg::T_FRAC;
    assign h_sum   = $signed(h_shift[H_W-1:0]) + {{(H_W-P_W){p_sel[P_W-1]}}, p_sel};

    always_comb
    begin
        if (h_sum > SAT_HI)
            sat_value = $signed(SAT_HI[KW-1:0]);
        else if (h_sum < SAT_LO)
            sat_value = $signed(SAT_LO[KW-1:0]);
        else
            sat_value = $signed(h_sum[KW-1:0]);
    end

    assign last_comp = (({1'b0, comp_reg} + cse_pkg::VPK_W'(1)) == depth_reg);

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        comp_next    = comp_reg;
        mac_vld_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next  = '0;
                comp_next = '0;
                if (eval_fire)
                    state_next = too_few ? ST_OUT : ST_SCALE;
            end
            ST_SCALE:
                state_next = ST_SPLIT;
            ST_SPLIT:
            begin
                cnt_next   = '0;
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                if (cnt_reg == 5'd4)
                begin
                    cnt_next   = '0;
                    state_next = ST_MAC;
                end
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            ST_MAC:
            begin
                if (mac_issue)
                begin
                    mac_vld_next = 1'b1;
                    cnt_next     = cnt_reg + 5'd1;
                end
                else
                begin
                    cnt_next   = 5'd1;
                    state_next = ST_HMUL;
                end
            end
            ST_HMUL:
                state_next = ST_HADD;
            ST_HADD:
            begin
                if (cnt_reg == 5'd3)
                    state_next = ST_OUT;
                else
                begin
                    cnt_next   = cnt_reg + 5'd1;
                    state_next = ST_HMUL;
                end
            end
            ST_OUT:
            begin
                if (rsp_fire)
                begin
                    if (rsp_reg.last)
                        state_next = ST_IDLE;
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        cnt_next   = '0;
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            comp_reg    <= '0;
            mac_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            comp_reg    <= comp_next;
            mac_vld_reg <= mac_vld_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knot_count_reg <= cse_pkg::KNOT_COUNT_RESET;
            vpk_reg        <= cse_pkg::VPK_RESET;
            basis_reg      <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                cse_pkg::REG_KNOT_COUNT:      knot_count_reg <= cfg_data[CW-1:0];
                cse_pkg::REG_VALUES_PER_KNOT: vpk_reg <= cfg_data[cse_pkg::VPK_W-1:0];
                cse_pkg::REG_BASIS_ROW_ZERO:  basis_reg[0] <= cfg_data;
                cse_pkg::REG_BASIS_ROW_ONE:   basis_reg[1] <= cfg_data;
                cse_pkg::REG_BASIS_ROW_TWO:   basis_reg[2] <= cfg_data;
                cse_pkg::REG_BASIS_ROW_THREE: basis_reg[3] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Knot store: one write port for write requests, one registered read port
    always_ff @(posedge clk)
    begin
        if (write_fire)
            store[req_data.knot_index] <= req_data.knot_value;
        rd_data_reg <= store[rd_addr];
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (eval_fire)
        begin
            alpha_reg  <= alpha_sat;
            nspans_reg <= n_eff - CW'(cse_pkg::SPAN_TAIL);
            depth_reg  <= depth_eff;
            if (too_few)
            begin
                rsp_reg.value     <= '0;
                rsp_reg.component <= '0;
                rsp_reg.last      <= 1'b1;
                rsp_reg.status    <= cse_pkg::STATUS_TOO_FEW;
            end
        end

        case (state_reg)
            ST_SCALE:
                prod_reg <= mul_out;
            ST_SPLIT:
            begin
                span_reg <= span_clamp;
                t_reg    <= t_full[cse_pkg::ALPHA_W-1:0];
            end
            ST_FETCH:
            begin
                // Read data arrives in the cycle after its address
                acc_reg <= '0;
                if (cnt_reg != 5'd0)
                    knot_reg[2'(cnt_reg[2:0] - 3'd1)] <= rd_data_reg;
            end
            ST_MAC:
            begin
                if (mac_issue)
                begin
                    prod_reg <= mul_out;
                    tag_reg  <= cnt_reg[3:0];
                end
                else
                    h_reg <= {{(H_W-P_W){p_reg[0][P_W-1]}}, p_reg[0]};
                if (mac_vld_reg)
                begin
                    if (tag_reg[1:0] == 2'd3)
                    begin
                        p_reg[tag_reg[3:2]] <= p_new;
                        acc_reg             <= '0;
                    end
                    else
                        acc_reg <= acc_sum;
                end
            end
            ST_HMUL:
                prod_reg <= mul_out;
            ST_HADD:
            begin
                h_reg <= h_sum;
                if (cnt_reg == 5'd3)
                begin
                    rsp_reg.value     <= sat_value;
                    rsp_reg.component <= comp_reg;
                    rsp_reg.last      <= last_comp;
                    rsp_reg.status    <= cse_pkg::STATUS_OK;
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    // No request is taken while a result is on offer.
    a_ready_excludes_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !rsp_valid)
        else $error("request taken while a result is pending");

    // Handing over the final result returns the block to idle.
    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_ready && rsp_data.last) |=> req_ready)
        else $error("block not idle after the final result");

    // An error result is always the single, final result of component zero.
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_data.status == cse_pkg::STATUS_TOO_FEW))
            |-> (rsp_data.last && (rsp_data.component == 2'd0)))
        else $error("malformed error result");

    // Component index stays within the latched component count.
    a_component_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ({1'b0, rsp_data.component} < depth_reg))
        else $error("component index beyond component count");

    // Products are only accumulated within the multiply-accumulate phase.
    a_mac_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
        mac_vld_reg |-> (state_reg == ST_MAC))
        else $error("accumulation outside the multiply-accumulate phase");
`endif

endmodule

FILE: bench/tb_cubic_spline_evaluator.sv
`timescale 1ns / 1ps
// Self-checking testbench for cubic_spline_evaluator: directed rows, then random phases.
// Depends on cse_pkg and the cubic_spline_evaluator RTL; needs nothing else.
module tb_cubic_spline_evaluator;

    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned PHASES         = 6;
    localparam int unsigned ITEM_BUDGET    = 180;
    localparam int unsigned DIRECTED_ROWS  = 29;
    localparam int unsigned REPORT_LIMIT   = 10;

    // Catmull-Rom basis (tension one half), one packed row per register
    localparam logic [cse_pkg::CFG_DATA_W-1:0] CATMULL_ROM [4] = '{
        64'h0800_E800_1800_F800, 64'hF800_2000_D800_1000,
        64'h0000_0800_0000_F800, 64'h0000_0000_1000_0000
    };
    localparam logic [cse_pkg::CFG_IDX_W-1:0] BASIS_REGS [4] = '{
        cse_pkg::REG_BASIS_ROW_ZERO, cse_pkg::REG_BASIS_ROW_ONE,
        cse_pkg::REG_BASIS_ROW_TWO, cse_pkg::REG_BASIS_ROW_THREE
    };

    typedef enum logic {
        ROW_REG = 1'b0,
        ROW_REQ = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t                          kind;
        logic [cse_pkg::CFG_IDX_W-1:0]      reg_index;
        logic [cse_pkg::CFG_DATA_W-1:0]     reg_data;
        cse_pkg::cmd_t                      command;
        logic [cse_pkg::STORE_AW-1:0]       knot_index;
        logic [cse_pkg::KNOT_W-1:0]         knot_value;
        logic [cse_pkg::ALPHA_W-1:0]        alpha;
        logic                               typed;
        logic [cse_pkg::KNOT_W-1:0]         typed_value;
        logic                               typed_status;
    } step_t;

    // Directed stimulus; rows with typed set carry their own expected value
    localparam step_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_REQ, cse_pkg::REG_KNOT_COUNT, 64'd0, cse_pkg::CMD_WRITE, 8'h00,
          32'h7FFF_FFFF, 17'h1FFFF, 1'b0, 32'd0, cse_pkg::STATUS_OK},
        '{ROW_REQ, cse_pkg::REG_KNOT_COUNT, 64'd0, cse_pkg::CMD_EVAL, 8'h00,
          32'd0, 17'h00000, 1'b1, 32'd0, cse_pkg::STATUS_OK},
        '{ROW_REG, cse_pkg::REG_KNOT_COUNT, 64'd3, cse_pkg::CMD_WRITE, 8'h00,
          32'd0, 17'd0, 1'b0, 32'd0, cse_pkg::STATUS_OK},
        '{ROW_REQ, cse_pkg::REG_KNOT_COUNT, 64'd0, cse_pkg::CMD_EVAL, 8'hFF,
          32'hFFFF_FFFF, 17'h1FFFF, 1'b1, 32'd0, cse_pkg::STATUS_TOO_FEW},
        '{ROW_REG, cse_pkg::REG_KNOT_COUNT, 64'd0, cse_pkg::CMD_WRITE, 8'h00,
          32'd0, 17'd0, 1'b0, 32'd0, cse_pkg::STATUS_OK},
        '{ROW_REQ, cse_pkg::REG_KNOT_COUNT, 64'd0, cse_pkg::CMD_EVAL, 8'h00,
          32'd0, 17'h00000, 1'b1, 32'd0, cse_pkg::STATUS_TOO_FEW},
        '{ROW_REG, cse_pkg::REG_KNOT_COUNT, 64'd4, cse_pkg::CMD_WRITE, 8'h00,
          32'd0, 17'd0, 1'b0, 32'd0, cse_pkg::STATUS_OK},
        '{ROW_REG, cse_pkg::REG_VALUES_PER_KNOT, 64'd1, cse_pkg::CMD_WRITE, 8'h00,
          32'd0, 17'd0, 1'b0, 32'd0, cse_pkg::STATUS_OK},
        '{ROW_REG, cse_pkg::REG_BASIS_ROW_THREE, 64'h7FFF, cse_pkg::CMD_WRITE, 8'h00,
          32'd0, 17'd0, 1'b0, 32'd0, cse_pkg::STATUS_OK},
        '{ROW_REQ, cse_pkg::REG_KNOT_COUNT, 64'd0, cse_pkg::CMD_EVAL, 8'h00,
          32'd0, 17'h00000, 1'b1, 32'h7FFF_FFFF, cse_pkg::STATUS_OK},
        '{ROW_REQ, cse_pkg::REG_KNOT_COUNT, 64'd0, cse_pkg::CMD_WRITE, 8'h00,
          32'h8000_0000, 17'h00000, 1'b0, 32'd0, cse_pkg::STATUS_OK},
        '{ROW_REQ, cse_pkg::REG_KNOT_COUNT, 64'd0, cse_pkg::CMD_EVAL, 8'h00,
          32'd0, 17'h00000, 1'b1, 32'h8000_0000, cse_pkg::STATUS_OK},
        '{ROW_REQ, cse_pkg::REG_KNOT_COUNT, 64'd0, cse_pkg::CMD_WRITE, 8'hFF,
          32'h1234_5678, 17'h10000, 1'b0, 32'd0, cse_pkg::STATUS_OK},
        '{ROW_REG, cse_pkg::REG_BASIS_ROW_ZERO, 64'h0800_E800_1800_F800,
          cse_pkg::CMD_WRITE, 8'h00, 32'd0, 17'd0, 1'b0, 32'd0, cse_pkg::STATUS_OK},
        '{ROW_REG, cse_pkg::REG_BASIS_ROW_ONE, 64'hF800_2000_D800_1000,
          cse_pkg::CMD_WRITE, 8'h00, 32'd0, 17'd0, 1'b0, 32'd0, cse_pkg::STATUS_OK},
        '{ROW_REG, cse_pkg::REG_BASIS_ROW_TWO, 64'h0000_0800_0000_F800,
          cse_pkg::CMD_WRITE, 8'h00, 32'd0, 17'd0, 1'b0, 32'd0, cse_pkg::STATUS_OK},
        '{ROW_REG, cse_pkg::REG_BASIS_ROW_THREE, 64'h0000_0000_1000_0000,
          cse_pkg::CMD_WRITE, 8'h00, 32'd0, 17'd0, 1'b0, 32'd0, cse_pkg::STATUS_OK},
        '{ROW_REG, cse_pkg::REG_KNOT_COUNT, 64'd127, cse_pkg::CMD_WRITE, 8'h00,
          32'd0, 17'd0, 1'b0, 32'd0, cse_pkg::STATUS_OK},
        '{ROW_REG, cse_pkg::REG_VALUES_PER_KNOT, 64'd7, cse_pkg::CMD_WRITE, 8'h00,
          32'd0, 17'd0, 1'b0, 32'd0, cse_pkg::STATUS_OK},
        '{ROW_REQ, cse_pkg::REG_KNOT_COUNT, 64'd0, cse_pkg::CMD_EVAL, 8'h00,
          32'd0, 17'h10000, 1'b0, 32'd0, cse_pkg::STATUS_OK},
        '{ROW_REQ, cse_pkg::REG_KNOT_COUNT, 64'd0, cse_pkg::CMD_EVAL, 8'h00,
          32'd0, 17'h1FFFF, 1'b0, 32'd0, cse_pkg::STATUS_OK},
        '{ROW_REQ, cse_pkg::REG_KNOT_COUNT, 64'd0, cse_pkg::CMD_EVAL, 8'h00,
          32'd0, 17'h08000, 1'b0, 32'd0, cse_pkg::STATUS_OK},
        '{ROW_REG, cse_pkg::REG_VALUES_PER_KNOT, 64'd0, cse_pkg::CMD_WRITE, 8'h00,
          32'd0, 17'd0, 1'b0, 32'd0, cse_pkg::STATUS_OK},
        '{ROW_REQ, cse_pkg::REG_KNOT_COUNT, 64'd0, cse_pkg::CMD_EVAL, 8'h00,
          32'd0, 17'h0FFFF, 1'b0, 32'd0, cse_pkg::STATUS_OK},
        '{ROW_REG, cse_pkg::REG_KNOT_COUNT, 64'd64, cse_pkg::CMD_WRITE, 8'h00,
          32'd0, 17'd0, 1'b0, 32'd0, cse_pkg::STATUS_OK},
        '{ROW_REG, cse_pkg::REG_VALUES_PER_KNOT, 64'd4, cse_pkg::CMD_WRITE, 8'h00,
          32'd0, 17'd0, 1'b0, 32'd0, cse_pkg::STATUS_OK},
        '{ROW_REQ, cse_pkg::REG_KNOT_COUNT, 64'd0, cse_pkg::CMD_EVAL, 8'h00,
          32'd0, 17'h00001, 1'b0, 32'd0, cse_pkg::STATUS_OK},
        '{ROW_REG, cse_pkg::REG_BASIS_ROW_ZERO, 64'h8000_7FFF_8000_7FFF,
          cse_pkg::CMD_WRITE, 8'h00, 32'd0, 17'd0, 1'b0, 32'd0, cse_pkg::STATUS_OK},
        '{ROW_REQ, cse_pkg::REG_KNOT_COUNT, 64'd0, cse_pkg::CMD_EVAL, 8'h00,
          32'd0, 17'h0C000, 1'b0, 32'd0, cse_pkg::STATUS_OK}
    };

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               req_valid = 1'b0;
    logic                               req_ready;
    cse_pkg::req_t                      req_data = '0;
    logic                               rsp_valid;
    logic                               rsp_ready = 1'b0;
    cse_pkg::rsp_t                      rsp_data;
    logic                               cfg_write = 1'b0;
    logic [cse_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [cse_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

    // Local copy of the block's state and configuration
    logic [cse_pkg::KNOT_W-1:0]         knot_mem [cse_pkg::STORE_DEPTH];
    bit                                 knot_written [cse_pkg::STORE_DEPTH];
    logic [cse_pkg::COUNT_W-1:0]        knots_loaded = cse_pkg::KNOT_COUNT_RESET;
    logic [cse_pkg::VPK_W-1:0]          vpk_loaded = cse_pkg::VPK_RESET;
    logic [cse_pkg::CFG_DATA_W-1:0]     basis [4] = '{default: '0};

    cse_pkg::rsp_t                      curve_points [$];
    int unsigned                        fault_count = 0;
    int unsigned                        quiet_cycles = 0;
    int unsigned                        sent_count = 0;
    bit                                 steady = 1'b0;

    cubic_spline_evaluator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned effective_knots();
        return (knots_loaded > cse_pkg::KNOT_CAP) ? cse_pkg::KNOT_CAP : knots_loaded;
    endfunction

    function automatic int unsigned lanes();
        if (vpk_loaded == 0)
            return 1;
        if (vpk_loaded > cse_pkg::DEPTH_LIMIT)
            return cse_pkg::DEPTH_LIMIT;
        return vpk_loaded;
    endfunction

    // Round half up after dropping s fraction bits; >>> floors a signed value
    function automatic longint round_shift(input longint v, input int unsigned s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // Span index and local fraction for one evaluation point
    function automatic void locate(input logic [cse_pkg::ALPHA_W-1:0] a,
                                   output int unsigned span, output int unsigned frac);
        int unsigned pos;
        int unsigned n_spans;
        int unsigned prod;
        pos = (a > cse_pkg::ALPHA_ONE) ? cse_pkg::ALPHA_ONE : a;
        n_spans = effective_knots() - cse_pkg::SPAN_TAIL;
        prod = pos * n_spans;
        span = prod >> cse_pkg::T_FRAC;
        if (span >= n_spans)
            span = n_spans - 1;
        frac = prod - (span << cse_pkg::T_FRAC);
    endfunction

    // Queues the results that one evaluation request should produce
    function automatic void interpolate(input logic [cse_pkg::ALPHA_W-1:0] a);
        int unsigned span;
        int unsigned frac;
        int unsigned depth;
        int unsigned i;
        int unsigned r;
        int unsigned k;
        longint acc;
        longint h;
        longint p [4];
        cse_pkg::rsp_t res;
        if (effective_knots() < cse_pkg::MIN_KNOTS)
        begin
            res.value = '0;
            res.component = 2'd0;
            res.last = 1'b1;
            res.status = cse_pkg::STATUS_TOO_FEW;
            curve_points.push_back(res);
            return;
        end
        locate(a, span, frac);
        depth = lanes();
        for (i = 0; i < depth; i++)
        begin
            // Basis matrix times the four span knots, Q.28 rounded to Q16.16
            for (r = 0; r < 4; r++)
            begin
                acc = 0;
                for (k = 0; k < 4; k++)
                    acc += longint'($signed(basis[r][cse_pkg::COEF_W*k +: cse_pkg::COEF_W]))
                         * longint'($signed(
                               knot_mem[cse_pkg::STORE_AW'((span + k) * depth + i)]));
                p[r] = round_shift(acc, cse_pkg::COEF_FRAC);
            end
            // Horner evaluation in the local fraction, then saturation
            h = p[0];
            for (r = 1; r < 4; r++)
                h = p[r] + round_shift(h * longint'(frac), cse_pkg::T_FRAC);
            if (h > 64'sh7FFF_FFFF)
                h = 64'sh7FFF_FFFF;
            if (h < -64'sh8000_0000)
                h = -64'sh8000_0000;
            res.value = h[cse_pkg::KNOT_W-1:0];
            res.component = 2'(i);
            res.last = (i == depth - 1);
            res.status = cse_pkg::STATUS_OK;
            curve_points.push_back(res);
        end
    endfunction

    function automatic logic [cse_pkg::KNOT_W-1:0] knot_sample();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        // Mostly modest values, within plus or minus 32.0
        return cse_pkg::KNOT_W'($urandom_range(0, 32'h0040_0000))
               - cse_pkg::KNOT_W'(32'h0020_0000);
    endfunction

    // One request: random gap, hold valid until ready, predict at acceptance
    task automatic send_request(input cse_pkg::req_t item, input bit predict);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= item;
        do @(negedge clk); while (req_ready !== 1'b1);
        sent_count++;
        if (item.command == cse_pkg::CMD_WRITE)
        begin
            knot_mem[item.knot_index] = item.knot_value;
            knot_written[item.knot_index] = 1'b1;
        end
        else if (predict)
            interpolate(item.alpha);
        @(posedge clk);
    endtask

    // Loads any knot component that an evaluation at a would read and that
    // has never been written, so that no undefined store entry is read.
    task automatic fill_span(input logic [cse_pkg::ALPHA_W-1:0] a);
        int unsigned span;
        int unsigned frac;
        int unsigned depth;
        int unsigned i;
        int unsigned k;
        logic [cse_pkg::STORE_AW-1:0] addr;
        cse_pkg::req_t load;
        if (effective_knots() < cse_pkg::MIN_KNOTS)
            return;
        locate(a, span, frac);
        depth = lanes();
        for (k = 0; k < 4; k++)
            for (i = 0; i < depth; i++)
            begin
                addr = cse_pkg::STORE_AW'((span + k) * depth + i);
                if (!knot_written[addr])
                begin
                    load.command = cse_pkg::CMD_WRITE;
                    load.knot_index = addr;
                    load.knot_value = knot_sample();
                    load.alpha = cse_pkg::ALPHA_W'($urandom);
                    send_request(load, 1'b1);
                end
            end
    endtask

    // Stops sending and waits until every expected result has been taken
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (curve_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [cse_pkg::CFG_IDX_W-1:0] index,
                                  input logic [cse_pkg::CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        case (index)
            cse_pkg::REG_KNOT_COUNT:      knots_loaded = data[cse_pkg::COUNT_W-1:0];
            cse_pkg::REG_VALUES_PER_KNOT: vpk_loaded = data[cse_pkg::VPK_W-1:0];
            cse_pkg::REG_BASIS_ROW_ZERO:  basis[0] = data;
            cse_pkg::REG_BASIS_ROW_ONE:   basis[1] = data;
            cse_pkg::REG_BASIS_ROW_TWO:   basis[2] = data;
            cse_pkg::REG_BASIS_ROW_THREE: basis[3] = data;
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Result side: random stalls, and each result checked against the oldest expectation
    initial
    begin : result_sink
        int unsigned stall;
        cse_pkg::rsp_t want;
        cse_pkg::rsp_t got;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 14);
            if (stall != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(negedge clk); while (rsp_valid !== 1'b1);
            got = rsp_data;
            if (curve_points.size() == 0)
            begin
                if (fault_count < REPORT_LIMIT)
                    $display("unexpected result: value %0d component %0d last %0b status %0b",
                             got.value, got.component, got.last, got.status);
                fault_count++;
            end
            else
            begin
                want = curve_points.pop_front();
                if (got.value !== want.value || got.component !== want.component ||
                    got.last !== want.last || got.status !== want.status)
                begin
                    if (fault_count < REPORT_LIMIT)
                        $display("exp/got value %0d/%0d comp %0d/%0d last %0b/%0b st %0b/%0b",
                                 want.value, got.value, want.component, got.component,
                                 want.last, got.last, want.status, got.status);
                    fault_count++;
                end
            end
            @(posedge clk);
        end
    end

    // Watchdog: too long without any request or result being taken
    always @(negedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stimulus: reset, directed rows, then random phases
    initial
    begin : stimulus
        step_t row;
        cse_pkg::req_t item;
        cse_pkg::rsp_t res;
        logic [cse_pkg::ALPHA_W-1:0] a;
        logic [cse_pkg::CFG_DATA_W-1:0] data;
        logic [cse_pkg::COUNT_W-1:0] count;
        logic [cse_pkg::VPK_W-1:0] depth_reg;
        int unsigned idx;
        int unsigned i;
        int unsigned r;
        int unsigned phase;
        int unsigned phase_end;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part
        for (idx = 0; idx < DIRECTED_ROWS; idx++)
        begin
            row = DIRECTED[idx];
            if (row.kind == ROW_REG)
            begin
                wait_idle();
                write_register(row.reg_index, row.reg_data);
            end
            else
            begin
                item.command = row.command;
                item.knot_index = row.knot_index;
                item.knot_value = row.knot_value;
                item.alpha = row.alpha;
                if (row.command == cse_pkg::CMD_EVAL)
                    fill_span(row.alpha);
                if (row.typed && row.typed_status == cse_pkg::STATUS_TOO_FEW)
                begin
                    res = '{value: '0, component: 2'd0, last: 1'b1,
                            status: cse_pkg::STATUS_TOO_FEW};
                    curve_points.push_back(res);
                end
                else if (row.typed)
                    for (i = 0; i < lanes(); i++)
                    begin
                        res.value = row.typed_value;
                        res.component = 2'(i);
                        res.last = (i == lanes() - 1);
                        res.status = cse_pkg::STATUS_OK;
                        curve_points.push_back(res);
                    end
                send_request(item, !row.typed);
            end
        end

        // Random phases, each under a fresh configuration
        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            steady = (phase % 3 == 2);
            case (phase)
                0:
                begin
                    count = 7'd127;
                    depth_reg = 3'd7;
                end
                1:
                begin
                    count = 7'd4;
                    depth_reg = 3'd0;
                end
                default:
                begin
                    case ($urandom_range(0, 5))
                        0:       count = cse_pkg::COUNT_W'($urandom_range(0, 3));
                        1:       count = 7'd64;
                        2:       count = 7'd127;
                        default: count = cse_pkg::COUNT_W'($urandom_range(4, 127));
                    endcase
                    depth_reg = cse_pkg::VPK_W'($urandom_range(0, 7));
                end
            endcase
            // Unused upper bits of the narrow registers carry noise
            data = {$urandom, $urandom};
            data[cse_pkg::COUNT_W-1:0] = count;
            write_register(cse_pkg::REG_KNOT_COUNT, data);
            data = {$urandom, $urandom};
            data[cse_pkg::VPK_W-1:0] = depth_reg;
            write_register(cse_pkg::REG_VALUES_PER_KNOT, data);
            for (r = 0; r < 4; r++)
            begin
                case ($urandom_range(0, 2))
                    0: data = {$urandom, $urandom};
                    1:
                        for (i = 0; i < 4; i++)
                            data[cse_pkg::COEF_W*i +: cse_pkg::COEF_W] =
                                cse_pkg::COEF_W'($urandom_range(0, 16'h2000))
                                - cse_pkg::COEF_W'(16'h1000);
                    default: data = CATMULL_ROM[r];
                endcase
                write_register(BASIS_REGS[r], data);
            end

            // Share what is left of the request budget among the remaining phases
            phase_end = sent_count + ((sent_count < ITEM_BUDGET) ?
                        (ITEM_BUDGET - sent_count) / (PHASES - phase) : 1);
            idx = 0;
            while (sent_count < phase_end)
            begin
                // Hold the sender once per phase until the block has drained
                if (idx == 2)
                    wait_idle();
                idx++;
                if ($urandom_range(0, 4) == 0)
                begin
                    item.command = cse_pkg::CMD_WRITE;
                    item.knot_index = cse_pkg::STORE_AW'($urandom);
                    item.knot_value = knot_sample();
                    item.alpha = cse_pkg::ALPHA_W'($urandom);
                end
                else
                begin
                    case ($urandom_range(0, 7))
                        0:       a = '0;
                        1:       a = cse_pkg::ALPHA_ONE;
                        2:       a = cse_pkg::ALPHA_W'($urandom_range(65537, 131071));
                        default: a = cse_pkg::ALPHA_W'($urandom_range(0, 65536));
                    endcase
                    fill_span(a);
                    item.command = cse_pkg::CMD_EVAL;
                    item.knot_index = cse_pkg::STORE_AW'($urandom);
                    item.knot_value = $urandom;
                    item.alpha = a;
                end
                send_request(item, 1'b1);
            end
        end

        // Drain, then report
        wait_idle();
        fault_count += curve_points.size();
        if (fault_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: cubic_spline_evaluator.f
sv/cse_pkg.sv
sv/cubic_spline_evaluator.sv
bench/tb_cubic_spline_evaluator.sv
